@@ rtl/fir_filter_streaming_top_macros.svh @@
// assertion macros for the streaming fir filter
`ifndef FIR_FILTER_STREAMING_TOP_MACROS_SVH
`define FIR_FILTER_STREAMING_TOP_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define FIRS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// antecedent followed by a consequent in the next cycle
`define FIRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// antecedent with a consequent in the same cycle
`define FIRS_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/firs_pkg.sv @@
// shared types and constants of the streaming fir filter
package firs_pkg;

    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int NT_W       = 8;
    localparam int ACC_W      = 64;

    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_COEF  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_TAPS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENVELOPE = 2'd1;

    localparam logic [NT_W-1:0] NUM_TAPS_RESET = 8'd65;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_ROUND,
        ST_OUT
    } firs_state_t;

endpackage

@@ rtl/firs_ram.sv @@
// generic single-port-write ram with registered read
module firs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/fir_filter_streaming_top.sv @@
// top level of the streaming direct-form fir filter with one shared mac
//
// usage
//   input channel (s_*): one request per item. s_opcode selects push sample,
//   write coefficient or clear history. only a push gives a result.
//   result channel (m_*): m_sample_out (q1.15, rounded and saturated) and
//   m_saturated, held in an output register until m_ready takes it.
//   config channel (cfg_*): index 0 num_taps, index 1 envelope_mode; always
//   ready; to be written by the user only while filter is idle, unenforced.
// processing
//   a push runs one multiply-accumulate per active tap through the shared mac,
//   via ram read, product and accumulate stages, then rounding and clipping
//   into the output register. coefficient writes and clears are taken while
//   idle and s_ready stays high. s_ready is low while a push runs, so the next
//   push is taken only once the previous result has been loaded.
// reset
//   aresetn low clears history valid bits, pointer and handshakes, num_taps
//   returns to 65 and envelope mode to off. coefficients are not cleared.
// stalls
//   while a result waits, the next item is still taken and filtered; its
//   result holds in the final stage until the output register frees up.
`include "fir_filter_streaming_top_macros.svh"

module fir_filter_streaming_top #(
    parameter int MAX_TAPS    = 128,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 18
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [firs_pkg::OP_W-1:0]        s_opcode,
    input  logic signed [SAMPLE_BITS-1:0]    s_sample_in,
    input  logic [$clog2(MAX_TAPS)-1:0]      s_coef_index,
    input  logic signed [COEF_BITS-1:0]      s_coef_value,
    // result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [SAMPLE_BITS-1:0]    m_sample_out,
    output logic                             m_saturated,
    // configuration channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [firs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [firs_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import firs_pkg::*;

    localparam int IDX_W  = $clog2(MAX_TAPS);
    localparam int CNT_W  = $clog2(MAX_TAPS + 1);
    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
    localparam int FS     = COEF_BITS - 3;
    localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1) << (FS - 1);
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] OUT_HI  = (ACC_W'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam logic signed [ACC_W-1:0] OUT_LO  = -OUT_HI - 1;

    // configuration
    logic [NT_W-1:0]  num_taps_reg;
    logic             envelope_reg;

    // sequencer and ring state
    firs_state_t      state_reg, state_next;
    logic [IDX_W-1:0] wp_reg;
    logic [MAX_TAPS-1:0] hist_vld_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [IDX_W-1:0] k_reg;

    // mac pipeline
    logic             rd_vld_reg;
    logic             rd_hvld_reg;
    logic             prod_vld_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  rnd_reg;

    // output register
    logic             out_vld_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic             out_sat_reg;

    // combinational
    logic [CNT_W-1:0] n_eff;
    logic [IDX_W-1:0] p_cur;
    logic [IDX_W-1:0] wp_after;
    logic             in_take;
    logic             issue;
    logic             mac_done;
    logic             out_load;
    logic             hist_we;
    logic             tap_we;
    logic signed [SAMPLE_BITS-1:0] hist_rdata;
    logic signed [COEF_BITS-1:0]   tap_rdata;
    logic signed [SAMPLE_BITS-1:0] hist_op;
    logic signed [ACC_W:0]         acc_sum;
    logic signed [ACC_W:0]         rnd_sum;
    logic signed [ACC_W-1:0]       rnd_sat;
    logic signed [ACC_W-1:0]       v_abs;

    assign cfg_ready = 1'b1;

    // tap count clamped into 1 .. MAX_TAPS
    always_comb begin
        if (num_taps_reg == '0) begin
            n_eff = CNT_W'(1);
        end else if (32'(num_taps_reg) > MAX_TAPS) begin
            n_eff = CNT_W'(MAX_TAPS);
        end else begin
            n_eff = CNT_W'(num_taps_reg);
        end
    end

    // slot for this push, stale pointer falls back to slot zero
    assign p_cur    = (32'(wp_reg) >= 32'(n_eff)) ? '0 : wp_reg;
    assign wp_after = (32'(p_cur) + 1 >= 32'(n_eff)) ? '0 : (p_cur + IDX_W'(1));

    assign in_take  = s_valid && s_ready;
    assign hist_we  = in_take && (s_opcode == OP_PUSH);
    assign tap_we   = in_take && (s_opcode == OP_COEF) && (32'(s_coef_index) < MAX_TAPS);

    // sequencer: idle, mac sweep with pipeline drain, round, clip and hand over
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        issue      = 1'b0;
        mac_done   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && (s_opcode == OP_PUSH)) begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                issue    = (cnt_reg < n_eff);
                mac_done = !issue && !rd_vld_reg && !prod_vld_reg;
                if (mac_done) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // wait for the output register to free up
                if (!out_vld_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_taps_reg <= NUM_TAPS_RESET;
            envelope_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_NUM_TAPS: num_taps_reg <= cfg_data[NT_W-1:0];
                CFG_ENVELOPE: envelope_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ring pointer and history valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg       <= '0;
            hist_vld_reg <= '0;
        end else if (in_take) begin
            unique case (s_opcode)
                OP_PUSH: begin
                    wp_reg              <= wp_after;
                    hist_vld_reg[p_cur] <= 1'b1;
                end
                OP_CLEAR: begin
                    wp_reg       <= '0;
                    hist_vld_reg <= '0;
                end
                default: ;
            endcase
        end
    end

    // tap counter and newest-to-oldest ring address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (hist_we) begin
            cnt_reg <= '0;
        end else if (issue) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (hist_we) begin
            k_reg <= p_cur;
        end else if (issue) begin
            k_reg <= (k_reg == '0) ? IDX_W'(n_eff - CNT_W'(1)) : (k_reg - IDX_W'(1));
        end
    end

    firs_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_TAPS)
    ) u_hist_ram (
        .clk   (aclk),
        .we    (hist_we),
        .waddr (p_cur),
        .wdata (s_sample_in),
        .raddr (k_reg),
        .rdata (hist_rdata)
    );

    firs_ram #(
        .WIDTH (COEF_BITS),
        .DEPTH (MAX_TAPS)
    ) u_tap_ram (
        .clk   (aclk),
        .we    (tap_we),
        .waddr (s_coef_index),
        .wdata (s_coef_value),
        .raddr (cnt_reg[IDX_W-1:0]),
        .rdata (tap_rdata)
    );

    // pipeline flags of the mac
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg   <= issue;
            prod_vld_reg <= rd_vld_reg;
        end
    end

    // an entry cleared since its last push reads as zero
    always_ff @(posedge aclk) begin
        rd_hvld_reg <= hist_vld_reg[k_reg];
    end

    assign hist_op = rd_hvld_reg ? hist_rdata : '0;

    // saturating accumulate of the registered product
    assign acc_sum = (ACC_W+1)'(acc_reg) + (ACC_W+1)'(prod_reg);

    always_ff @(posedge aclk) begin
        if (rd_vld_reg) begin
            prod_reg <= hist_op * tap_rdata;
        end
        if (hist_we) begin
            acc_reg <= '0;
        end else if (prod_vld_reg) begin
            if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
                acc_reg <= acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
            end else begin
                acc_reg <= acc_sum[ACC_W-1:0];
            end
        end
    end

    // round half up, then floor shift back to q1.15
    assign rnd_sum = (ACC_W+1)'(acc_reg) + (ACC_W+1)'(HALF);
    assign rnd_sat = (rnd_sum[ACC_W] != rnd_sum[ACC_W-1]) ? ACC_MAX : rnd_sum[ACC_W-1:0];

    always_ff @(posedge aclk) begin
        if (state_reg == ST_ROUND) begin
            rnd_reg <= rnd_sat >>> FS;
        end
    end

    // magnitude before clipping in envelope mode
    assign v_abs = (envelope_reg && (rnd_reg < 0)) ? -rnd_reg : rnd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_load) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (v_abs > OUT_HI) begin
                out_sample_reg <= OUT_HI[SAMPLE_BITS-1:0];
                out_sat_reg    <= 1'b1;
            end else if (v_abs < OUT_LO) begin
                out_sample_reg <= OUT_LO[SAMPLE_BITS-1:0];
                out_sat_reg    <= 1'b1;
            end else begin
                out_sample_reg <= v_abs[SAMPLE_BITS-1:0];
                out_sat_reg    <= 1'b0;
            end
        end
    end

    assign m_valid      = out_vld_reg;
    assign m_sample_out = out_sample_reg;
    assign m_saturated  = out_sat_reg;

    // checks on the sequencer and ring addressing
    `FIRS_ASSERT_NEXT(a_push_starts_mac, hist_we, state_reg == ST_MAC, "push did not start mac")
    `FIRS_ASSERT_IMPLY(a_cnt_in_range, state_reg == ST_MAC, cnt_reg <= n_eff, "tap count overrun")
    `FIRS_ASSERT_IMPLY(a_ring_addr, state_reg == ST_MAC, 32'(k_reg) < 32'(n_eff), "ring address out of range")
    `FIRS_ASSERT_IMPLY(a_load_from_out, $rose(out_vld_reg), $past(state_reg) == ST_OUT, "result loaded outside final stage")

endmodule

@@ tb/tb.sv @@
// self-checking testbench for the streaming direct-form fir filter
`timescale 1ns / 100ps

module tb;
    import firs_pkg::*;

    localparam int MAX_TAPS    = 128;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 18;
    localparam int IDX_W       = $clog2(MAX_TAPS);

    // opcode and register indexes the package leaves unnamed
    localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE3 = 2'd3;

    // tail wait: allow margin over a full push in the 128 tap case
    localparam int TAIL_CYCLES  = MAX_TAPS + 12;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int RANDOM_ITEMS = 1200;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          saturated;
    } filt_result_t;

    // clock, reset and dut ports; the driven ones are known from time zero
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                          s_valid      = 1'b0;
    logic                          s_ready;
    logic [OP_W-1:0]               s_opcode     = OP_PUSH;
    logic signed [SAMPLE_BITS-1:0] s_sample_in  = '0;
    logic [IDX_W-1:0]              s_coef_index = '0;
    logic signed [COEF_BITS-1:0]   s_coef_value = '0;

    logic                          m_valid;
    logic                          m_ready      = 1'b0;
    logic signed [SAMPLE_BITS-1:0] m_sample_out;
    logic                          m_saturated;

    logic                          cfg_valid    = 1'b0;
    logic                          cfg_ready;
    logic [CFG_IDX_W-1:0]          cfg_index    = '0;
    logic [CFG_DATA_W-1:0]         cfg_data     = '0;

    // predictor state: history ring, pointer, taps and the two registers
    logic signed [SAMPLE_BITS-1:0] hist_mirror [MAX_TAPS];
    logic signed [COEF_BITS-1:0]   tap_mirror  [MAX_TAPS];
    int unsigned                   wr_ptr_mirror;
    logic [NT_W-1:0]               num_taps_reg;
    logic                          envelope_reg;

    // filtered samples still owed by the dut, oldest first
    filt_result_t filtered_q [$];
    filt_result_t owed;

    // run bookkeeping
    int          mismatch_count = 0;
    int          results_seen   = 0;
    int          sat_seen       = 0;
    int          pushes_sent    = 0;
    int          random_items   = 0;
    int          settings_used  = 0;
    int unsigned cycle_count    = 0;

    // sender and receiver pacing
    bit idle_on     = 1'b1;
    int pending_gap = 0;
    bit s_held      = 1'b0;
    int ready_hold  = 0;
    int ready_draw;

    fir_filter_streaming_top #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_sample_in  (s_sample_in),
        .s_coef_index (s_coef_index),
        .s_coef_value (s_coef_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .m_saturated  (m_saturated),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 20 ns period
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("fir_filter_streaming_top verification failed");
            $finish;
        end
    end

    // receiver: after each taken result, m_ready may drop for a random hold when pacing is on
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_hold = 0;
        end else if (m_valid && m_ready) begin
            ready_draw = idle_on ? int'($urandom_range(0, 3)) : 0;
            ready_hold = ready_draw;
            m_ready    <= (ready_draw == 0);
        end else if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
            m_ready    <= (ready_hold == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // result checker: each taken result against the oldest owed one
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (filtered_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: sample_out %0d saturated %0b",
                             m_sample_out, m_saturated);
            end else begin
                owed = filtered_q.pop_front();
                if (owed.saturated) sat_seen++;
                if (m_sample_out !== owed.sample_out || m_saturated !== owed.saturated) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch at result %0d: expected %0d/%0b, got %0d/%0b",
                                 results_seen, owed.sample_out, owed.saturated,
                                 m_sample_out, m_saturated);
                end
            end
        end
    end

    // --------------------------------------------------------------------
    // predictor
    // --------------------------------------------------------------------

    // one push: store the sample, run the tap sum, round, fold and clip
    task automatic filter_push(input logic signed [SAMPLE_BITS-1:0] smp);
        int unsigned  n;
        int unsigned  p;
        int unsigned  k;
        longint       acc;
        longint       v;
        filt_result_t r;
        n = 32'(num_taps_reg);
        if (n == 0) n = 1;
        if (n > MAX_TAPS) n = MAX_TAPS;
        // a pointer left past the ring after a shrink restarts at slot 0
        p = wr_ptr_mirror;
        if (p >= n) p = 0;
        hist_mirror[p] = smp;
        acc = 0;
        for (int unsigned j = 0; j < n; j++) begin
            k = (p >= j) ? (p - j) : (p + n - j);
            acc += longint'(tap_mirror[j]) * longint'(hist_mirror[k]);
        end
        // round half up, then back to q1.15
        v = (acc + (64'sd1 <<< (COEF_BITS - 4))) >>> (COEF_BITS - 3);
        if (envelope_reg && v < 0) v = -v;
        r.saturated = 1'b0;
        if (v > 32767) begin
            v = 32767;
            r.saturated = 1'b1;
        end
        if (v < -32768) begin
            v = -32768;
            r.saturated = 1'b1;
        end
        r.sample_out = v[SAMPLE_BITS-1:0];
        filtered_q.push_back(r);
        wr_ptr_mirror = (p + 1 >= n) ? 0 : p + 1;
    endtask

    task automatic apply_item(input logic [OP_W-1:0] op,
                              input logic signed [SAMPLE_BITS-1:0] smp,
                              input logic [IDX_W-1:0] idx,
                              input logic signed [COEF_BITS-1:0] cv);
        case (op)
            OP_PUSH: begin
                filter_push(smp);
                pushes_sent++;
            end
            OP_COEF: begin
                tap_mirror[idx] = cv;
            end
            OP_CLEAR: begin
                foreach (hist_mirror[i]) hist_mirror[i] = '0;
                wr_ptr_mirror = 0;
            end
            default: ;
        endcase
    endtask

    // --------------------------------------------------------------------
    // channel drivers
    // --------------------------------------------------------------------

    // drop s_valid if it was left high for a back-to-back request
    task automatic park_sender();
        if (s_held) begin
            s_valid <= 1'b0;
            s_held  = 1'b0;
        end
    endtask

    // one request on the input channel; returns at the accepting edge
    task automatic send_item(input logic [OP_W-1:0] op,
                             input logic signed [SAMPLE_BITS-1:0] smp,
                             input logic [IDX_W-1:0] idx,
                             input logic signed [COEF_BITS-1:0] cv);
        repeat (pending_gap) @(posedge aclk);
        s_valid      <= 1'b1;
        s_opcode     <= op;
        s_sample_in  <= smp;
        s_coef_index <= idx;
        s_coef_value <= cv;
        do @(posedge aclk); while (!s_ready);
        apply_item(op, smp, idx, cv);
        // draw the gap before the next request now, so valid is lowered once
        pending_gap = idle_on ? int'($urandom_range(0, 3)) : 0;
        if (pending_gap != 0)
            s_valid <= 1'b0;
        s_held = (pending_gap == 0);
    endtask

    task automatic push(input logic signed [SAMPLE_BITS-1:0] smp);
        send_item(OP_PUSH, smp, '0, '0);
    endtask

    task automatic write_tap(input logic [IDX_W-1:0] idx,
                             input logic signed [COEF_BITS-1:0] cv);
        send_item(OP_COEF, '0, idx, cv);
    endtask

    // sender holds off until every owed result is in
    task automatic drain();
        park_sender();
        do @(posedge aclk); while (filtered_q.size() != 0);
    endtask

    // drain, then let a full filter latency pass so the block is idle
    task automatic wait_idle();
        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // register write; only called once the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        park_sender();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_NUM_TAPS: num_taps_reg = data;
            CFG_ENVELOPE: envelope_reg = data[0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // both registers, with random spare bits in the envelope write
    task automatic configure(input logic [NT_W-1:0] taps, input logic env);
        logic [CFG_DATA_W-1:0] env_word;
        wait_idle();
        env_word    = CFG_DATA_W'($urandom);
        env_word[0] = env;
        write_reg(CFG_NUM_TAPS, taps);
        write_reg(CFG_ENVELOPE, env_word);
        settings_used++;
    endtask

    // --------------------------------------------------------------------
    // tests
    // --------------------------------------------------------------------

    // every tap gets a value first, so no push ever reads an unset tap
    task automatic test_load_taps();
        logic signed [COEF_BITS-1:0] cv;
        for (int i = 0; i < MAX_TAPS; i++) begin
            cv = COEF_BITS'($urandom);
            if (i == 0)            cv = 18'sh1ffff;
            if (i == 1)            cv = -18'sh20000;
            if (i == MAX_TAPS - 1) cv = -18'sh20000;
            write_tap(i[IDX_W-1:0], cv);
        end
    endtask

    // short hand-picked list: extremes, rounding ties, envelope corners
    task automatic test_directed();
        idle_on = 1'b0;
        configure(8'd3, 1'b0);
        // spare register indexes must leave both registers alone
        write_reg(CFG_SPARE2, 8'hff);
        write_reg(CFG_SPARE3, 8'h00);
        write_tap(7'd0, 18'sd32768);    // unity gain on the newest sample
        write_tap(7'd1, '0);
        write_tap(7'd2, '0);
        push(16'sd32767);
        push(-16'sd32768);
        push(16'sd0);
        push(16'sd1);
        push(-16'sd1);
        // gain near four clips both ways
        write_tap(7'd0, 18'sh1ffff);
        push(16'sd32767);
        push(-16'sd32768);
        write_tap(7'd0, -18'sh20000);
        push(-16'sd32768);
        // smallest tap: positive tie rounds up, negative tie rounds to zero
        write_tap(7'd0, 18'sd1);
        push(16'sd16384);
        push(-16'sd16384);
        // clear history and the unused opcode
        send_item(OP_CLEAR, 16'sh7fff, 7'h7f, 18'sh1ffff);
        send_item(OP_UNUSED, 16'sh7fff, 7'h7f, 18'sh1ffff);
        push(16'sd1000);
        // envelope: full-scale negative folds to 32768 and clips
        configure(8'd3, 1'b1);
        write_tap(7'd0, 18'sd32768);
        push(-16'sd32768);
        write_tap(7'd0, -18'sd32768);
        push(16'sd32767);
        push(-16'sd32768);
        idle_on = 1'b1;
    endtask

    // tap counts at and past the ends, and a pointer left stale by a shrink
    task automatic test_tap_counts();
        logic [NT_W-1:0] counts [7];
        counts = '{8'd1, 8'd0, 8'd2, 8'd128, 8'd255, 8'd129, NUM_TAPS_RESET};
        foreach (counts[c]) begin
            configure(counts[c], c[0]);
            for (int i = 0; i < 4; i++) push(SAMPLE_BITS'($urandom));
        end
        // seven pushes into a ten-tap ring leave the pointer at seven
        configure(8'd10, 1'b0);
        send_item(OP_CLEAR, '0, '0, '0);
        for (int i = 0; i < 7; i++) push(SAMPLE_BITS'($urandom));
        // shrinking to four puts the next push in slot 0
        configure(8'd4, 1'b0);
        for (int i = 0; i < 6; i++) push(SAMPLE_BITS'($urandom));
        configure(8'd12, 1'b1);
        for (int i = 0; i < 5; i++) push(SAMPLE_BITS'($urandom));
    endtask

    // random phases: fresh settings, a partial tap reload, then mixed requests
    task automatic test_random();
        int                          pick;
        int                          n_act;
        int                          coef_shift;
        logic [NT_W-1:0]             taps;
        logic signed [SAMPLE_BITS-1:0] smp;
        logic signed [COEF_BITS-1:0] cv;
        logic [IDX_W-1:0]            idx;
        while (random_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)      taps = NT_W'($urandom_range(1, 16));
            else if (pick < 85) taps = NT_W'($urandom_range(17, 127));
            else if (pick < 95) taps = 8'd128;
            else if (pick < 97) taps = 8'd0;
            else                taps = NT_W'($urandom_range(129, 255));
            idle_on = ($urandom_range(0, 3) != 0);
            configure(taps, 1'($urandom_range(0, 1)));
            n_act = (taps == 0) ? 1 : (int'(taps) > MAX_TAPS) ? MAX_TAPS : int'(taps);
            // small shifts give clipping, large ones keep sums in range
            coef_shift = $urandom_range(0, 12);
            for (int i = 0; i < n_act && i < 24; i++) begin
                cv = COEF_BITS'($urandom);
                write_tap(i[IDX_W-1:0], cv >>> coef_shift);
                random_items++;
            end
            for (int i = 0; i < 60; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    case ($urandom_range(0, 9))
                        0:       smp = 16'sd32767;
                        1:       smp = -16'sd32768;
                        default: smp = SAMPLE_BITS'($urandom);
                    endcase
                    push(smp);
                    random_items++;
                end else if (pick < 85) begin
                    cv  = COEF_BITS'($urandom);
                    idx = IDX_W'($urandom);
                    write_tap(idx, cv >>> coef_shift);
                    random_items++;
                end else if (pick < 90) begin
                    send_item(OP_CLEAR, SAMPLE_BITS'($urandom), IDX_W'($urandom),
                              COEF_BITS'($urandom));
                    random_items++;
                end else begin
                    send_item(OP_UNUSED, SAMPLE_BITS'($urandom), IDX_W'($urandom),
                              COEF_BITS'($urandom));
                end
                // now and then the sender waits for the pipe to empty
                if ($urandom_range(0, 39) == 0)
                    drain();
            end
        end
    endtask

    // --------------------------------------------------------------------
    // sequence
    // --------------------------------------------------------------------
    initial begin
        foreach (hist_mirror[i]) hist_mirror[i] = '0;
        foreach (tap_mirror[i])  tap_mirror[i]  = '0;
        wr_ptr_mirror = 0;
        num_taps_reg  = NUM_TAPS_RESET;
        envelope_reg  = 1'b0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_load_taps();
        test_directed();
        test_tap_counts();
        test_random();

        // tail: every owed result in, then one more filter latency
        wait_idle();
        if (filtered_q.size() != 0) begin
            mismatch_count++;
            $display("%0d filtered samples never arrived", filtered_q.size());
        end

        $display("covered %0d samples pushed over %0d tap/envelope settings, %0d clipped",
                 pushes_sent, settings_used, sat_seen);
        $display("%0d results checked, %0d mismatches", results_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("fir_filter_streaming_top verification clean");
        end else begin
            $display("fir_filter_streaming_top verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/firs_pkg.sv
rtl/firs_ram.sv
rtl/fir_filter_streaming_top.sv
tb/tb.sv
